[rtl/tpp_pkg.sv]
// Shared types and constants for the torus playfield pointer block.
// Used by the controller, the datapath and the top level; depends on nothing.
package tpp_pkg;

    localparam int MAX_COLS = 128;
    localparam int MAX_ROWS = 32;
    localparam int COL_W    = $clog2(MAX_COLS);
    localparam int ROW_W    = $clog2(MAX_ROWS);
    localparam int ADDR_W   = COL_W + ROW_W;
    localparam int WIDTH_W  = 8;
    localparam int HEIGHT_W = 6;
    localparam int DATA_W   = 8;
    localparam int TDATA_W  = 32;

    localparam logic [2:0] KIND_STEP  = 3'd0;
    localparam logic [2:0] KIND_SETH  = 3'd1;
    localparam logic [2:0] KIND_REV   = 3'd2;
    localparam logic [2:0] KIND_WRITE = 3'd3;
    localparam logic [2:0] KIND_READ  = 3'd4;

    localparam logic [1:0] HEAD_RIGHT = 2'd0;
    localparam logic [1:0] HEAD_LEFT  = 2'd1;
    localparam logic [1:0] HEAD_UP    = 2'd2;
    localparam logic [1:0] HEAD_DOWN  = 2'd3;

    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 8'd80;
    localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 6'd25;

    // Input item as it sits in s_tdata, lowest field last.
    typedef struct packed {
        logic [6:0]        pad;
        logic [DATA_W-1:0] cell_value;
        logic [ROW_W-1:0]  cell_row;
        logic [COL_W-1:0]  cell_col;
        logic [1:0]        new_heading;
        logic [2:0]        kind;
    } in_item_t;

    // Result item as it sits in m_tdata, lowest field last.
    typedef struct packed {
        logic              pad;
        logic              cell_in_range;
        logic [DATA_W-1:0] read_value;
        logic [DATA_W-1:0] char_under_ptr;
        logic [1:0]        ptr_heading;
        logic [ROW_W-1:0]  ptr_row;
        logic [COL_W-1:0]  ptr_col;
    } out_item_t;

    typedef struct packed {
        logic accept;
        logic mod_start;
        logic commit;
        logic load_out;
    } ctrl_cmd_t;

    typedef struct packed {
        logic need_mod;
        logic mod_done;
    } ctrl_status_t;

endpackage

[rtl/tpp_mod.sv]
// Bit-serial remainder unit used to wrap the pointer when it steps from outside the grid.
// Depends on tpp_pkg for the operand width.
module tpp_mod (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [tpp_pkg::WIDTH_W-1:0] dividend,
    input  logic [tpp_pkg::WIDTH_W-1:0] divisor,
    output logic                        done,
    output logic [tpp_pkg::WIDTH_W-1:0] rem
);

    localparam int CNT_W = $clog2(tpp_pkg::WIDTH_W);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(tpp_pkg::WIDTH_W - 1);

    logic                        busy_reg, busy_next;
    logic                        done_reg, done_next;
    logic [CNT_W-1:0]            cnt_reg, cnt_next;
    logic [tpp_pkg::WIDTH_W-1:0] dvd_reg, dvd_next;
    logic [tpp_pkg::WIDTH_W-1:0] dsr_reg, dsr_next;
    logic [tpp_pkg::WIDTH_W-1:0] rem_reg, rem_next;
    logic [tpp_pkg::WIDTH_W-1:0] trial;

    // The partial remainder stays below the divisor, so its top bit is always zero.
    assign trial = {rem_reg[tpp_pkg::WIDTH_W-2:0], dvd_reg[tpp_pkg::WIDTH_W-1]};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        dsr_next  = dsr_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            dvd_next  = dividend;
            dsr_next  = divisor;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            dvd_next = {dvd_reg[tpp_pkg::WIDTH_W-2:0], 1'b0};
            rem_next = (trial >= dsr_reg) ? (trial - dsr_reg) : trial;
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == LAST_STEP)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        dsr_reg <= dsr_next;
        rem_reg <= rem_next;
    end

    assign done = done_reg;
    assign rem  = rem_reg;

endmodule

[rtl/tpp_datapath.sv]
// Datapath: grid size registers, pointer registers, cell memory and result register.
// Depends on tpp_pkg and instantiates tpp_mod.
module tpp_datapath (
    input  logic                         clk,
    input  logic                         rst_n,
    input  tpp_pkg::ctrl_cmd_t           cmd,
    output tpp_pkg::ctrl_status_t        status,
    input  logic [tpp_pkg::TDATA_W-1:0]  in_data,
    input  logic                         cfg_we,
    input  logic                         cfg_index,
    input  logic [tpp_pkg::WIDTH_W-1:0]  cfg_data,
    output logic [tpp_pkg::TDATA_W-1:0]  out_data
);

    localparam int DEPTH = tpp_pkg::MAX_COLS * tpp_pkg::MAX_ROWS;

    tpp_pkg::in_item_t           item_reg;
    tpp_pkg::out_item_t          out_reg, out_next;

    logic [tpp_pkg::WIDTH_W-1:0]  width_reg;
    logic [tpp_pkg::HEIGHT_W-1:0] height_reg;
    logic [tpp_pkg::WIDTH_W-1:0]  w_eff;
    logic [tpp_pkg::HEIGHT_W-1:0] h_eff;

    logic [tpp_pkg::COL_W-1:0]    ptr_col_reg, ptr_col_next;
    logic [tpp_pkg::ROW_W-1:0]    ptr_row_reg, ptr_row_next;
    logic [1:0]                   heading_reg, heading_next;
    logic                         use_mod_reg;

    logic [tpp_pkg::WIDTH_W-1:0]  col_inc;
    logic [tpp_pkg::HEIGHT_W-1:0] row_inc;
    logic [tpp_pkg::WIDTH_W-1:0]  mod_dividend, mod_divisor, mod_rem;
    logic                         mod_done;

    logic                         cell_in, ptr_in, mem_we;
    logic [tpp_pkg::ADDR_W-1:0]   cell_addr, ptr_addr;

    logic [tpp_pkg::DATA_W-1:0]   cell_mem [DEPTH];
    logic [tpp_pkg::DATA_W-1:0]   rd_ptr_reg, rd_cell_reg;
    logic                         fwd_reg, ptr_in_reg, cell_in_reg;

    // Sizes in use are the registers clamped to 1..MAX.
    always_comb
    begin
        if (width_reg == '0)
            w_eff = tpp_pkg::WIDTH_W'(1);
        else if (width_reg > tpp_pkg::WIDTH_W'(tpp_pkg::MAX_COLS))
            w_eff = tpp_pkg::WIDTH_W'(tpp_pkg::MAX_COLS);
        else
            w_eff = width_reg;
        if (height_reg == '0)
            h_eff = tpp_pkg::HEIGHT_W'(1);
        else if (height_reg > tpp_pkg::HEIGHT_W'(tpp_pkg::MAX_ROWS))
            h_eff = tpp_pkg::HEIGHT_W'(tpp_pkg::MAX_ROWS);
        else
            h_eff = height_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= tpp_pkg::WIDTH_RESET;
            height_reg <= tpp_pkg::HEIGHT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                tpp_pkg::REG_WIDTH:  width_reg  <= cfg_data;
                tpp_pkg::REG_HEIGHT: height_reg <= cfg_data[tpp_pkg::HEIGHT_W-1:0];
                default:             width_reg  <= width_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
            item_reg <= tpp_pkg::in_item_t'(in_data);
    end

    assign col_inc = tpp_pkg::WIDTH_W'(ptr_col_reg) + 1'b1;
    assign row_inc = tpp_pkg::HEIGHT_W'(ptr_row_reg) + 1'b1;

    // A step right or down from beyond the grid edge needs a true remainder.
    assign mod_dividend = (heading_reg == tpp_pkg::HEAD_DOWN) ?
                          tpp_pkg::WIDTH_W'(row_inc) : col_inc;
    assign mod_divisor  = (heading_reg == tpp_pkg::HEAD_DOWN) ?
                          tpp_pkg::WIDTH_W'(h_eff) : w_eff;

    assign status.need_mod = (item_reg.kind == tpp_pkg::KIND_STEP) && !use_mod_reg &&
                             (((heading_reg == tpp_pkg::HEAD_RIGHT) && (col_inc > w_eff)) ||
                              ((heading_reg == tpp_pkg::HEAD_DOWN) && (row_inc > h_eff)));
    assign status.mod_done = mod_done;

    tpp_mod u_mod (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.mod_start),
        .dividend (mod_dividend),
        .divisor  (mod_divisor),
        .done     (mod_done),
        .rem      (mod_rem)
    );

    // Pointer after the operation.
    always_comb
    begin
        ptr_col_next = ptr_col_reg;
        ptr_row_next = ptr_row_reg;
        heading_next = heading_reg;
        case (item_reg.kind)
            tpp_pkg::KIND_STEP:
            begin
                unique case (heading_reg)
                    tpp_pkg::HEAD_RIGHT:
                        if (use_mod_reg)
                            ptr_col_next = mod_rem[tpp_pkg::COL_W-1:0];
                        else if (col_inc == w_eff)
                            ptr_col_next = '0;
                        else
                            ptr_col_next = col_inc[tpp_pkg::COL_W-1:0];
                    tpp_pkg::HEAD_LEFT:
                        if (ptr_col_reg == '0)
                            ptr_col_next = tpp_pkg::COL_W'(w_eff - 1'b1);
                        else
                            ptr_col_next = ptr_col_reg - 1'b1;
                    tpp_pkg::HEAD_UP:
                        if (ptr_row_reg == '0)
                            ptr_row_next = tpp_pkg::ROW_W'(h_eff - 1'b1);
                        else
                            ptr_row_next = ptr_row_reg - 1'b1;
                    tpp_pkg::HEAD_DOWN:
                        if (use_mod_reg)
                            ptr_row_next = mod_rem[tpp_pkg::ROW_W-1:0];
                        else if (row_inc == h_eff)
                            ptr_row_next = '0;
                        else
                            ptr_row_next = row_inc[tpp_pkg::ROW_W-1:0];
                    default:
                        ptr_col_next = ptr_col_reg;
                endcase
            end
            tpp_pkg::KIND_SETH: heading_next = item_reg.new_heading;
            tpp_pkg::KIND_REV:  heading_next = heading_reg ^ 2'd1;
            default:            heading_next = heading_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_col_reg <= '0;
            ptr_row_reg <= '0;
            heading_reg <= tpp_pkg::HEAD_RIGHT;
            use_mod_reg <= 1'b0;
        end
        else
        begin
            if (cmd.commit)
            begin
                ptr_col_reg <= ptr_col_next;
                ptr_row_reg <= ptr_row_next;
                heading_reg <= heading_next;
            end
            if (cmd.accept)
                use_mod_reg <= 1'b0;
            else if (mod_done)
                use_mod_reg <= 1'b1;
        end
    end

    assign cell_in = (tpp_pkg::WIDTH_W'(item_reg.cell_col) < w_eff) &&
                     (tpp_pkg::HEIGHT_W'(item_reg.cell_row) < h_eff);
    assign ptr_in  = (tpp_pkg::WIDTH_W'(ptr_col_next) < w_eff) &&
                     (tpp_pkg::HEIGHT_W'(ptr_row_next) < h_eff);

    assign cell_addr = {item_reg.cell_row, item_reg.cell_col};
    assign ptr_addr  = {ptr_row_next, ptr_col_next};
    assign mem_we    = cmd.commit && (item_reg.kind == tpp_pkg::KIND_WRITE) && cell_in;

    // One write port and two registered read ports. A write to the cell under
    // the pointer in the same cycle is forwarded at the result stage.
    always_ff @(posedge clk)
    begin
        if (mem_we)
            cell_mem[cell_addr] <= item_reg.cell_value;
        if (cmd.commit)
        begin
            rd_ptr_reg  <= cell_mem[ptr_addr];
            rd_cell_reg <= cell_mem[cell_addr];
            fwd_reg     <= mem_we && (cell_addr == ptr_addr);
            ptr_in_reg  <= ptr_in;
            cell_in_reg <= cell_in;
        end
    end

    always_comb
    begin
        out_next                = '0;
        out_next.ptr_col        = ptr_col_reg;
        out_next.ptr_row        = ptr_row_reg;
        out_next.ptr_heading    = heading_reg;
        if (ptr_in_reg)
            out_next.char_under_ptr = fwd_reg ? item_reg.cell_value : rd_ptr_reg;
        if ((item_reg.kind == tpp_pkg::KIND_READ) && cell_in_reg)
            out_next.read_value = rd_cell_reg;
        out_next.cell_in_range  = ((item_reg.kind == tpp_pkg::KIND_WRITE) ||
                                   (item_reg.kind == tpp_pkg::KIND_READ)) && cell_in_reg;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
            out_reg <= out_next;
    end

    assign out_data = tpp_pkg::TDATA_W'(out_reg);

endmodule

[rtl/tpp_ctrl.sv]
// Controller state machine: input handshake, sequencing of one item, output valid.
// Depends on tpp_pkg for the command and status structs.
module tpp_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    input  tpp_pkg::ctrl_status_t status,
    output tpp_pkg::ctrl_cmd_t    cmd
);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_EXEC   = 4'b0010,
        ST_MOD    = 4'b0100,
        ST_FINISH = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign out_free = !out_valid_reg || m_tready;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !m_tready;
        cmd            = '0;
        s_tready       = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.accept = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (status.need_mod)
                begin
                    cmd.mod_start = 1'b1;
                    state_next    = ST_MOD;
                end
                else
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_FINISH;
                end
            end
            ST_MOD:
            begin
                if (status.mod_done)
                    state_next = ST_EXEC;
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    s_tready       = 1'b1;
                    if (s_tvalid)
                    begin
                        cmd.accept = 1'b1;
                        state_next = ST_EXEC;
                    end
                    else
                        state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_tvalid = out_valid_reg;

endmodule

[rtl/torus_playfield_pointer.sv]
// Top level of the torus playfield pointer: a byte grid with a wrapping pointer.
// Depends on tpp_pkg and instantiates tpp_ctrl and tpp_datapath.
//
// Usage: each item on the slave stream is one operation (step, set heading,
// reverse heading, write a cell, read a cell) and yields exactly one result
// item on the master stream. The result carries the pointer after the
// operation, the byte under the pointer, the byte read and the in-range flag.
// Load the program with write items before stepping; cells never written
// read as unknown values.
// The grid size is set through the write port (index 0 width, index 1 height)
// and must only be changed while no item is in flight.
// A result is registered after the pointer update and the memory read.
// When the pointer steps right or down from outside a grid that shrank,
// the wrap is first computed by the bit-serial remainder unit.
// A new item is taken only when the result of the last one is loaded
// into the output register, after the synchronous cell memory read.
// Reset clears the pointer to column 0, row 0, heading right, and the grid
// size to 80 by 25; the cell memory keeps whatever it held.
// A stalled receiver holds the result in the output register; the block takes
// one more item, works it up to the memory read, and then waits there.
module torus_playfield_pointer (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // kind[2:0], new_heading[4:3], cell_col[11:5], cell_row[16:12],
    // cell_value[24:17], zeros[31:25]
    input  logic [tpp_pkg::TDATA_W-1:0]  s_tdata,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // ptr_col[6:0], ptr_row[11:7], ptr_heading[13:12], char_under_ptr[21:14],
    // read_value[29:22], cell_in_range[30], zero[31]
    output logic [tpp_pkg::TDATA_W-1:0]  m_tdata,
    input  logic                         cfg_we,
    input  logic                         cfg_index,
    input  logic [tpp_pkg::WIDTH_W-1:0]  cfg_data
);

    tpp_pkg::ctrl_cmd_t    cmd;
    tpp_pkg::ctrl_status_t status;

    // The controller sequences each item; the datapath owns the grid, pointer, memory and result state.
    tpp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    tpp_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .in_data   (s_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_data  (m_tdata)
    );

endmodule

[rtl/tpp_checker.sv]
// Port-level checks for torus_playfield_pointer, attached by the bind at the end.
// Depends only on the top level's port list.
module tpp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata
);

    // A held result keeps its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result changed while stalled");

    // After an item is taken, s_tready is low in the cycle after.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("item taken in back-to-back cycles");

    // A result that is not in range never carries a read byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[30] |-> m_tdata[29:22] == 8'd0)
        else $error("read value without an in-range cell");

    // While reset is low at a clock edge, any pending result is cleared.
    assert property (@(posedge clk) !rst_n |=> !m_tvalid)
        else $error("result valid during reset");

endmodule

bind torus_playfield_pointer tpp_checker u_tpp_checker (.*);
